>>> rtl/assert_macros.svh
// Assertion macros shared by the trace buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

>>> rtl/tbr_pkg.sv
// Types, register offsets and codes for the trace buffer.
package tbr_pkg;

    localparam int DATA_W            = 32;
    localparam int DEFAULT_RAM_DEPTH = 1024;

    // Request kinds
    localparam logic [1:0] FUNC_READ    = 2'd0;
    localparam logic [1:0] FUNC_WRITE   = 2'd1;
    localparam logic [1:0] FUNC_TRACE   = 2'd2;
    localparam logic [1:0] FUNC_TRIGGER = 2'd3;

    // Register offsets
    localparam logic [11:0] OFS_DEPTH  = 12'h004;
    localparam logic [11:0] OFS_STATUS = 12'h00c;
    localparam logic [11:0] OFS_RDATA  = 12'h010;
    localparam logic [11:0] OFS_RPTR   = 12'h014;
    localparam logic [11:0] OFS_WPTR   = 12'h018;
    localparam logic [11:0] OFS_TRG    = 12'h01c;
    localparam logic [11:0] OFS_CTL    = 12'h020;
    localparam logic [11:0] OFS_WDATA  = 12'h024;
    localparam logic [11:0] OFS_FFSR   = 12'h300;
    localparam logic [11:0] OFS_FFCR   = 12'h304;

    // Stored formatter control bits
    localparam int FC_EN_FTC    = 0;
    localparam int FC_EN_FCONT  = 1;
    localparam int FC_STOP_FL   = 2;
    localparam int FC_STOP_TRIG = 3;

    // Bus positions in the formatter control register
    localparam int FFCR_EN_FTC    = 0;
    localparam int FFCR_EN_FCONT  = 1;
    localparam int FFCR_FLUSH     = 6;
    localparam int FFCR_STOP_FL   = 12;
    localparam int FFCR_STOP_TRIG = 13;

    typedef struct packed {
        logic [1:0]        func;
        logic [11:0]       reg_offset;
        logic [DATA_W-1:0] data_word;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              known_register;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RAM_RD,
        ST_MOD
    } tbr_state_t;

endpackage

>>> rtl/tbr_ram.sv
// Trace word RAM: one write port, one read port with registered data.
module tbr_ram #(
    parameter int RAM_DEPTH = tbr_pkg::DEFAULT_RAM_DEPTH,
    parameter int ADDR_W    = $clog2(RAM_DEPTH)
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [tbr_pkg::DATA_W-1:0] wdata,
    input  logic                      re,
    input  logic [ADDR_W-1:0]         raddr,
    output logic [tbr_pkg::DATA_W-1:0] rdata
);
    import tbr_pkg::*;

    logic [DATA_W-1:0] mem [RAM_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered data
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tbr_mod.sv
// Remainder of a 32-bit word by the RAM depth, by reciprocal multiplication.
`include "assert_macros.svh"

module tbr_mod #(
    parameter int RAM_DEPTH = tbr_pkg::DEFAULT_RAM_DEPTH,
    parameter int PTR_W     = $clog2(RAM_DEPTH)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [tbr_pkg::DATA_W-1:0] value,
    output logic                       done,
    output logic [PTR_W-1:0]           result
);
    import tbr_pkg::*;

    // quotient = (value * RECIP) >> SHIFT is exact for every 32-bit value
    localparam int          SHIFT    = DATA_W + PTR_W;
    localparam logic [63:0] RECIP    = ((64'd1 << SHIFT) + 64'(RAM_DEPTH) - 64'd1) /
                                       64'(RAM_DEPTH);
    localparam logic [15:0] RECIP_LO = RECIP[15:0];
    localparam logic [16:0] RECIP_HI = RECIP[32:16];
    localparam int          PROD_W   = DATA_W + 33;

    logic [DATA_W-1:0]  val_reg, val_next;
    logic [DATA_W+15:0] plo_reg, plo_next;
    logic [DATA_W+16:0] phi_reg, phi_next;
    logic [PTR_W-1:0]   quo_reg, quo_next;
    logic [PTR_W-1:0]   rem_reg, rem_next;
    logic               s1_reg, s2_reg, s3_reg, done_reg;
    logic [PROD_W-1:0]  prod;

    // three stages: split product, quotient, remainder from low bits
    always_comb begin
        val_next = start ? value : val_reg;
        plo_next = {16'd0, val_reg} * {{DATA_W{1'b0}}, RECIP_LO};
        phi_next = {17'd0, val_reg} * {{DATA_W{1'b0}}, RECIP_HI};
        prod     = {phi_reg, 16'd0} + {17'd0, plo_reg};
        quo_next = PTR_W'(prod >> SHIFT);
        // true remainder is below RAM_DEPTH, so the low bits suffice
        rem_next = val_reg[PTR_W-1:0] - PTR_W'(quo_reg * PTR_W'(RAM_DEPTH));
    end

    // stage flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg   <= 1'b0;
            s2_reg   <= 1'b0;
            s3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            s1_reg   <= start;
            s2_reg   <= s1_reg;
            s3_reg   <= s2_reg;
            done_reg <= s3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        plo_reg <= plo_next;
        phi_reg <= phi_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done   = done_reg;
    assign result = rem_reg;

    `ASSERT_NEVER(a_rem_range, aclk, aresetn, done_reg && (DATA_W'(rem_reg) >= DATA_W'(RAM_DEPTH)))
    `ASSERT_NEVER(a_start_busy, aclk, aresetn, start && (s1_reg || s2_reg || s3_reg || done_reg))
    `ASSERT_AT(a_done_once, aclk, aresetn, done_reg |=> !done_reg)

endmodule

>>> rtl/trace_buffer_ram_registers.sv
// Trace capture buffer: circular trace RAM behind a register window.
// A result is ready in the cycle after its request; a read of the read-data register
// passes through the registered read of the trace RAM before the result queue.
// Throughput: one request per cycle while fewer than two results wait; no request is
// taken while a read-data register read or a pointer write (remainder unit) is pending.
// Reset (synchronous, active low) clears pointers, flags and control but sets the stopped flag; RAM is not cleared.
`include "assert_macros.svh"

module trace_buffer_ram_registers #(
    parameter int RAM_DEPTH = tbr_pkg::DEFAULT_RAM_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tbr_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output tbr_pkg::out_item_t m_item
);
    import tbr_pkg::*;

    localparam int PTR_W = $clog2(RAM_DEPTH);

    tbr_state_t state_reg, state_next;

    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic              full_reg, full_next;
    logic              cap_en_reg, cap_en_next;
    logic [3:0]        fc_reg, fc_next;
    logic [DATA_W-1:0] trig_rem_reg, trig_rem_next;
    logic              triggered_reg, triggered_next;
    logic              stopped_reg, stopped_next;
    logic              tgt_wp_reg, tgt_wp_next;

    // two-entry result queue
    out_item_t ent_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       head_reg, head_next;

    logic              s_fire, pop, push, push_acc;
    logic              rdata_req;
    out_item_t         rsp, push_item;
    logic              running;
    logic [PTR_W-1:0]  wp_inc, rp_inc;
    logic [DATA_W-1:0] trig_dec;
    logic [DATA_W-1:0] rd_val;
    logic              known;

    logic              ram_we, ram_re;
    logic [DATA_W-1:0] ram_rdata;
    logic              mod_start, mod_done;
    logic [PTR_W-1:0]  mod_res;
    logic [3:0]        fc_wr;

    tbr_ram #(
        .RAM_DEPTH (RAM_DEPTH),
        .ADDR_W    (PTR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (s_item.data_word),
        .re    (ram_re),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    tbr_mod #(
        .RAM_DEPTH (RAM_DEPTH),
        .PTR_W     (PTR_W)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .value   (s_item.data_word),
        .done    (mod_done),
        .result  (mod_res)
    );

    // handy terms
    assign s_fire    = s_valid && s_ready;
    assign pop       = m_valid && m_ready;
    assign running   = cap_en_reg && !stopped_reg;
    assign wp_inc    = (wp_reg == PTR_W'(RAM_DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
    assign rp_inc    = (rp_reg == PTR_W'(RAM_DEPTH - 1)) ? '0 : rp_reg + PTR_W'(1);
    assign trig_dec  = (trig_rem_reg != '0) ? trig_rem_reg - DATA_W'(1) : trig_rem_reg;
    assign rdata_req = (s_item.func == FUNC_READ) && (s_item.reg_offset == OFS_RDATA);
    assign fc_wr     = {s_item.data_word[FFCR_STOP_TRIG], s_item.data_word[FFCR_STOP_FL],
                        s_item.data_word[FFCR_EN_FCONT], s_item.data_word[FFCR_EN_FTC]};

    // register decode and read mux
    always_comb begin
        known  = 1'b1;
        rd_val = '0;
        case (s_item.reg_offset)
            OFS_DEPTH:  rd_val = DATA_W'(RAM_DEPTH);
            OFS_STATUS: rd_val = {28'd0, stopped_reg, stopped_reg, triggered_reg, full_reg};
            OFS_RDATA:  rd_val = '0;
            OFS_RPTR:   rd_val = DATA_W'(rp_reg);
            OFS_WPTR:   rd_val = DATA_W'(wp_reg);
            OFS_TRG:    rd_val = trig_rem_reg;
            OFS_CTL:    rd_val = {31'd0, cap_en_reg};
            OFS_WDATA:  rd_val = '0;
            OFS_FFSR:   rd_val = {30'd0, stopped_reg, 1'b0};
            OFS_FFCR:   rd_val = {18'd0, fc_reg[FC_STOP_TRIG], fc_reg[FC_STOP_FL], 10'd0,
                                  fc_reg[FC_EN_FCONT], fc_reg[FC_EN_FTC]};
            default: begin
                known  = 1'b0;
                rd_val = '0;
            end
        endcase
    end

    // request execution: state update, RAM access, response
    always_comb begin
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        full_next      = full_reg;
        cap_en_next    = cap_en_reg;
        fc_next        = fc_reg;
        trig_rem_next  = trig_rem_reg;
        triggered_next = triggered_reg;
        stopped_next   = stopped_reg;
        tgt_wp_next    = tgt_wp_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        mod_start      = 1'b0;
        rsp            = '0;
        push_acc       = 1'b0;
        if (s_fire) begin
            push_acc = !rdata_req;
            case (s_item.func)
                FUNC_READ: begin
                    rsp.known_register = known;
                    rsp.read_data      = rd_val;
                    if (rdata_req) begin
                        ram_re  = 1'b1;
                        rp_next = rp_inc;
                    end
                end
                FUNC_WRITE: begin
                    rsp.known_register = known;
                    case (s_item.reg_offset)
                        OFS_RPTR: begin
                            mod_start   = 1'b1;
                            tgt_wp_next = 1'b0;
                        end
                        OFS_WPTR: begin
                            mod_start   = 1'b1;
                            tgt_wp_next = 1'b1;
                            full_next   = 1'b0;
                        end
                        OFS_TRG: trig_rem_next = s_item.data_word;
                        OFS_CTL: begin
                            cap_en_next = s_item.data_word[0];
                            if (s_item.data_word[0] && !cap_en_reg) begin
                                stopped_next   = 1'b0;
                                triggered_next = 1'b0;
                            end
                            if (!s_item.data_word[0]) begin
                                stopped_next = 1'b1;
                            end
                        end
                        OFS_WDATA: begin
                            ram_we  = 1'b1;
                            wp_next = wp_inc;
                            if (wp_inc == '0) begin
                                full_next = 1'b1;
                            end
                        end
                        OFS_FFCR: begin
                            fc_next = fc_wr;
                            if (s_item.data_word[FFCR_FLUSH] && fc_wr[FC_STOP_FL]) begin
                                stopped_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                FUNC_TRACE: begin
                    if (running) begin
                        ram_we  = 1'b1;
                        wp_next = wp_inc;
                        if (wp_inc == '0) begin
                            full_next = 1'b1;
                        end
                        if (triggered_reg) begin
                            trig_rem_next = trig_dec;
                            if (trig_dec == '0 && fc_reg[FC_STOP_TRIG]) begin
                                stopped_next = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    if (running && !triggered_reg) begin
                        triggered_next = 1'b1;
                        if (trig_rem_reg == '0 && fc_reg[FC_STOP_TRIG]) begin
                            stopped_next = 1'b1;
                        end
                    end
                end
            endcase
        end
        // reduced pointer value lands
        if (mod_done) begin
            if (tgt_wp_reg) begin
                wp_next = mod_res;
            end else begin
                rp_next = mod_res;
            end
        end
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && rdata_req) begin
                    state_next = ST_RAM_RD;
                end else if (mod_start) begin
                    state_next = ST_MOD;
                end
            end
            ST_RAM_RD: state_next = ST_IDLE;
            ST_MOD: begin
                if (mod_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        push      = push_acc;
        push_item = rsp;
        case (state_reg)
            ST_IDLE: s_ready = (cnt_reg != 2'd2);
            ST_RAM_RD: begin
                push      = 1'b1;
                push_item = '{read_data: ram_rdata, known_register: 1'b1};
            end
            ST_MOD: s_ready = 1'b0;
            default: s_ready = 1'b0;
        endcase
    end

    // result queue bookkeeping
    always_comb begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
        if (pop) begin
            head_next = ~head_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[head_reg ^ cnt_reg[0]] <= push_item;
        end
    end

    assign m_valid = (cnt_reg != 2'd0);
    assign m_item  = ent_reg[head_reg];

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            full_reg      <= 1'b0;
            cap_en_reg    <= 1'b0;
            fc_reg        <= '0;
            trig_rem_reg  <= '0;
            triggered_reg <= 1'b0;
            stopped_reg   <= 1'b1;
            tgt_wp_reg    <= 1'b0;
            cnt_reg       <= '0;
            head_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            full_reg      <= full_next;
            cap_en_reg    <= cap_en_next;
            fc_reg        <= fc_next;
            trig_rem_reg  <= trig_rem_next;
            triggered_reg <= triggered_next;
            stopped_reg   <= stopped_next;
            tgt_wp_reg    <= tgt_wp_next;
            cnt_reg       <= cnt_next;
            head_reg      <= head_next;
        end
    end

    `ASSERT_NEVER(a_queue_overflow, aclk, aresetn, push && !pop && cnt_reg == 2'd2)
    `ASSERT_NEVER(a_wp_range, aclk, aresetn, DATA_W'(wp_reg) >= DATA_W'(RAM_DEPTH))
    `ASSERT_NEVER(a_rp_range, aclk, aresetn, DATA_W'(rp_reg) >= DATA_W'(RAM_DEPTH))
    `ASSERT_AT(a_rdata_resp, aclk, aresetn, s_fire && rdata_req |=> push && !push_acc)
    `ASSERT_AT(a_mod_done_state, aclk, aresetn, mod_done |-> state_reg == ST_MOD)

endmodule
